>>> rtl/integrate_fire_neuron_array_macros.svh
// Assertion macros for the integrate-and-fire neuron array.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef INTEGRATE_FIRE_NEURON_ARRAY_MACROS_SVH
`define INTEGRATE_FIRE_NEURON_ARRAY_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IFNA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IFNA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ifna_pkg.sv
// Shared types and constants for the integrate-and-fire neuron array.
// No dependencies; used by the front end, the command queue, the back end and the top level.
package ifna_pkg;

    localparam int NEURONS     = 64;
    localparam int IDX_W       = 6;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = 7;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_ADD  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic KIND_EXCITE  = 1'b0;
    localparam logic KIND_INHIBIT = 1'b1;

    localparam logic [CNT_W-1:0] ACTIVE_RESET = CNT_W'(NEURONS);

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_ADD_EXC,
        CMD_ADD_INH,
        CMD_TICK
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] level;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD_WB,
        ST_TICK_DIFF,
        ST_TICK_UPD
    } back_state_t;

endpackage

>>> rtl/ifna_front.sv
// Front end: accepts input words, drops those that do nothing, and encodes the rest.
// Depends on ifna_pkg; feeds ifna_queue.
module ifna_front (
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               opcode,
    input  logic [5:0]               neuron_sel,
    input  logic                     synapse_kind,
    input  logic signed [31:0]       value,
    input  logic signed [31:0]       fire_level,
    input  logic                     q_full,
    output logic                     push,
    output ifna_pkg::cmd_t           push_cmd
);
    import ifna_pkg::*;

    logic      idx_ok;
    logic      known_op;
    cmd_kind_t kind;

    assign in_ready = !q_full;
    assign idx_ok   = ({1'b0, neuron_sel} < CNT_W'(NEURONS));

    always_comb
    begin
        known_op = 1'b1;
        kind     = CMD_TICK;
        unique case (opcode)
            OP_LOAD: kind = CMD_LOAD;
            OP_ADD:  kind = (synapse_kind == KIND_INHIBIT) ? CMD_ADD_INH : CMD_ADD_EXC;
            OP_TICK: kind = CMD_TICK;
            default: known_op = 1'b0;
        endcase
    end

    // Drop unknown opcodes and out-of-range neurons; ticks ignore the index.
    assign push = in_valid && in_ready && known_op && (idx_ok || kind == CMD_TICK);

    assign push_cmd.kind  = kind;
    assign push_cmd.index = neuron_sel;
    assign push_cmd.value = value;
    assign push_cmd.level = fire_level;

endmodule

>>> rtl/ifna_queue.sv
// Short command queue between the front end and the back end.
// Depends on ifna_pkg for the command type and depth.
module ifna_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ifna_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output ifna_pkg::cmd_t  head
);
    import ifna_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/ifna_back.sv
// Back end: executes load, add and tick commands against the neuron memories.
// Depends on ifna_pkg and the assertion macros header; drains ifna_queue.
`include "integrate_fire_neuron_array_macros.svh"

module ifna_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    input  ifna_pkg::cmd_t           cmd,
    output logic                     cmd_pop,
    input  logic [6:0]               active_count,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [5:0]               out_index,
    output logic signed [31:0]       recorded_voltage,
    output logic                     spiked,
    output logic                     last
);
    import ifna_pkg::*;

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    function automatic logic signed [DATA_W-1:0] sat_fit(input logic signed [DATA_W:0] s);
        if (s[DATA_W] != s[DATA_W-1])
        begin
            sat_fit = s[DATA_W] ? SAT_MIN : SAT_MAX;
        end
        else
        begin
            sat_fit = s[DATA_W-1:0];
        end
    endfunction

    // Neuron memories; accumulators read as zero until their valid bit is set.
    logic [DATA_W-1:0] membrane_mem  [NEURONS];
    logic [DATA_W-1:0] threshold_mem [NEURONS];
    logic [DATA_W-1:0] excite_mem    [NEURONS];
    logic [DATA_W-1:0] inhibit_mem   [NEURONS];

    logic [DATA_W-1:0] rd_v_reg, rd_t_reg, rd_e_reg, rd_i_reg;
    logic [NEURONS-1:0] exc_valid_reg, exc_valid_next;
    logic [NEURONS-1:0] inh_valid_reg, inh_valid_next;

    back_state_t        state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [IDX_W-1:0]   n_reg, n_next;
    logic [IDX_W-1:0]   last_n_reg, last_n_next;
    logic signed [DATA_W-1:0] diff_reg, diff_next;
    logic signed [DATA_W-1:0] before_reg, before_next;
    logic signed [DATA_W-1:0] thr_reg, thr_next;

    logic               out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]   out_index_reg, out_index_next;
    logic signed [DATA_W-1:0] out_voltage_reg, out_voltage_next;
    logic               out_spiked_reg, out_spiked_next;
    logic               out_last_reg, out_last_next;

    logic [CNT_W-1:0]   tick_count;
    logic [IDX_W-1:0]   rd_addr;
    logic               out_free;
    logic               advance;
    logic               v_we, t_we, e_we, i_we;
    logic [IDX_W-1:0]   v_waddr;
    logic [DATA_W-1:0]  v_wdata;
    logic signed [DATA_W-1:0] acc_old, acc_sum, exc_in, inh_in, after;
    logic               fire;

    assign tick_count = (active_count > CNT_W'(NEURONS)) ? CNT_W'(NEURONS) : active_count;
    assign out_free   = !out_valid_reg || out_ready;

    assign exc_in = exc_valid_reg[n_reg] ? $signed(rd_e_reg) : '0;
    assign inh_in = inh_valid_reg[n_reg] ? $signed(rd_i_reg) : '0;
    assign after  = sat_fit({before_reg[DATA_W-1], before_reg} + {diff_reg[DATA_W-1], diff_reg});
    assign fire   = (after > thr_reg);

    always_comb
    begin
        if (cmd_reg.kind == CMD_ADD_INH)
        begin
            acc_old = inh_valid_reg[cmd_reg.index] ? $signed(rd_i_reg) : '0;
        end
        else
        begin
            acc_old = exc_valid_reg[cmd_reg.index] ? $signed(rd_e_reg) : '0;
        end
        acc_sum = sat_fit({acc_old[DATA_W-1], acc_old} +
                          {cmd_reg.value[DATA_W-1], $signed(cmd_reg.value)});
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.kind)
                        CMD_LOAD:    state_next = ST_IDLE;
                        CMD_ADD_EXC: state_next = ST_ADD_WB;
                        CMD_ADD_INH: state_next = ST_ADD_WB;
                        CMD_TICK:    state_next = (tick_count == '0) ? ST_IDLE : ST_TICK_DIFF;
                    endcase
                end
            end
            ST_ADD_WB:    state_next = ST_IDLE;
            ST_TICK_DIFF: state_next = ST_TICK_UPD;
            ST_TICK_UPD:
            begin
                if (out_free)
                begin
                    state_next = (n_reg == last_n_reg) ? ST_IDLE : ST_TICK_DIFF;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath controls.
    always_comb
    begin
        cmd_pop          = 1'b0;
        advance          = 1'b0;
        rd_addr          = cmd.index;
        v_we             = 1'b0;
        t_we             = 1'b0;
        e_we             = 1'b0;
        i_we             = 1'b0;
        v_waddr          = cmd.index;
        v_wdata          = cmd.value;
        cmd_next         = cmd_reg;
        n_next           = n_reg;
        last_n_next      = last_n_reg;
        diff_next        = diff_reg;
        before_next      = before_reg;
        thr_next         = thr_reg;
        exc_valid_next   = exc_valid_reg;
        inh_valid_next   = inh_valid_reg;
        out_index_next   = out_index_reg;
        out_voltage_next = out_voltage_reg;
        out_spiked_next  = out_spiked_reg;
        out_last_next    = out_last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_pop  = cmd_valid;
                cmd_next = cmd;
                if (cmd.kind == CMD_TICK)
                begin
                    rd_addr     = '0;
                    n_next      = '0;
                    last_n_next = IDX_W'(tick_count - 1'b1);
                end
                if (cmd_valid && cmd.kind == CMD_LOAD)
                begin
                    v_we = 1'b1;
                    t_we = 1'b1;
                    exc_valid_next[cmd.index] = 1'b0;
                    inh_valid_next[cmd.index] = 1'b0;
                end
            end
            ST_ADD_WB:
            begin
                if (cmd_reg.kind == CMD_ADD_INH)
                begin
                    i_we = 1'b1;
                    inh_valid_next[cmd_reg.index] = 1'b1;
                end
                else
                begin
                    e_we = 1'b1;
                    exc_valid_next[cmd_reg.index] = 1'b1;
                end
            end
            ST_TICK_DIFF:
            begin
                rd_addr     = n_reg;
                diff_next   = sat_fit({exc_in[DATA_W-1], exc_in} - {inh_in[DATA_W-1], inh_in});
                before_next = $signed(rd_v_reg);
                thr_next    = $signed(rd_t_reg);
            end
            ST_TICK_UPD:
            begin
                // Prefetch the next neuron while this one retires.
                rd_addr = n_reg + 1'b1;
                if (out_free)
                begin
                    advance          = 1'b1;
                    v_we             = 1'b1;
                    v_waddr          = n_reg;
                    v_wdata          = fire ? '0 : after;
                    exc_valid_next[n_reg] = 1'b0;
                    inh_valid_next[n_reg] = 1'b0;
                    out_index_next   = n_reg;
                    out_voltage_next = before_reg;
                    out_spiked_next  = fire;
                    out_last_next    = (n_reg == last_n_reg);
                    n_next           = n_reg + 1'b1;
                end
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            exc_valid_reg <= '0;
            inh_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            exc_valid_reg <= exc_valid_next;
            inh_valid_reg <= inh_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        n_reg           <= n_next;
        last_n_reg      <= last_n_next;
        diff_reg        <= diff_next;
        before_reg      <= before_next;
        thr_reg         <= thr_next;
        out_index_reg   <= out_index_next;
        out_voltage_reg <= out_voltage_next;
        out_spiked_reg  <= out_spiked_next;
        out_last_reg    <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            membrane_mem[v_waddr] <= v_wdata;
        end
        rd_v_reg <= membrane_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            threshold_mem[cmd.index] <= cmd.level;
        end
        rd_t_reg <= threshold_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            excite_mem[cmd_reg.index] <= acc_sum;
        end
        rd_e_reg <= excite_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (i_we)
        begin
            inhibit_mem[cmd_reg.index] <= acc_sum;
        end
        rd_i_reg <= inhibit_mem[rd_addr];
    end

    assign out_valid        = out_valid_reg;
    assign out_index        = out_index_reg;
    assign recorded_voltage = out_voltage_reg;
    assign spiked           = out_spiked_reg;
    assign last             = out_last_reg;

    `IFNA_ASSERT_NXT(a_add_one_wb, state_reg == ST_ADD_WB, state_reg == ST_IDLE, "add writeback did not return to idle")
    `IFNA_ASSERT_NXT(a_diff_to_upd, state_reg == ST_TICK_DIFF, state_reg == ST_TICK_UPD, "tick difference stage not followed by update")
    `IFNA_ASSERT_NXT(a_last_flag, advance && (n_reg == last_n_reg), out_valid_reg && out_last_reg && (state_reg == ST_IDLE), "final neuron of tick not flagged")
    `IFNA_ASSERT_NXT(a_acc_cleared, advance, !exc_valid_reg[$past(n_reg)] && !inh_valid_reg[$past(n_reg)], "accumulators not cleared after tick update")
    `IFNA_ASSERT_IMP(a_pop_idle, cmd_pop, (state_reg == ST_IDLE) && !advance, "command taken while busy")

endmodule

>>> rtl/integrate_fire_neuron_array.sv
// Top level of the integrate-and-fire neuron array: config register, front end, queue, back end.
// Depends on ifna_pkg, ifna_front, ifna_queue and ifna_back.
//
//   channel   signals                                         direction
//   in        in_valid/in_ready, opcode..fire_level           command words in
//   out       out_valid/out_ready, out_index..last            one word per ticked neuron
//   cfg       cfg_valid/cfg_ready, cfg_wdata                  active neuron count
//
// An accepted word is registered in the command queue before it reaches the back end.
// In the back end a load is written straight from idle; an add does a memory read, then a saturating write.
// A tick walks each active neuron through read, difference and update, holding while the output word waits.
// Reset clears the accumulators at once through per-neuron valid bits; no clearing pass.
// The two-entry command queue takes words while the back end waits on out_ready;
// in_ready drops once both entries are taken.
module integrate_fire_neuron_array (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          opcode,
    input  logic [5:0]          neuron_sel,
    input  logic                synapse_kind,
    input  logic signed [31:0]  value,
    input  logic signed [31:0]  fire_level,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [5:0]          out_index,
    output logic signed [31:0]  recorded_voltage,
    output logic                spiked,
    output logic                last,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [6:0]          cfg_wdata
);
    import ifna_pkg::*;

    logic [CNT_W-1:0] active_reg, active_next;
    logic             q_full;
    logic             q_push;
    cmd_t             q_push_cmd;
    logic             q_pop;
    logic             q_not_empty;
    cmd_t             q_head;

    assign cfg_ready   = 1'b1;
    assign active_next = (cfg_valid && cfg_ready) ? cfg_wdata : active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    ifna_front u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .neuron_sel   (neuron_sel),
        .synapse_kind (synapse_kind),
        .value        (value),
        .fire_level   (fire_level),
        .q_full       (q_full),
        .push         (q_push),
        .push_cmd     (q_push_cmd)
    );

    ifna_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    ifna_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd_valid        (q_not_empty),
        .cmd              (q_head),
        .cmd_pop          (q_pop),
        .active_count     (active_reg),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_index        (out_index),
        .recorded_voltage (recorded_voltage),
        .spiked           (spiked),
        .last             (last)
    );

endmodule

>>> tb/integrate_fire_neuron_array_test.sv
`timescale 1ns / 1ps
// Self-checking bench for integrate_fire_neuron_array: loads, a directed table, then random phases.
// Depends on ifna_pkg and the RTL top; tick reports are checked against the table or a predictor.
module integrate_fire_neuron_array_test;
    import ifna_pkg::*;

    localparam logic [1:0]         OP_UNUSED     = 2'd3;
    localparam logic signed [31:0] S32_MAX       = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN       = 32'sh8000_0000;
    localparam logic signed [31:0] V_ONE         = 32'sh0000_8000;
    localparam logic signed [31:0] V_TWO         = 32'sh0001_0000;
    localparam logic signed [31:0] V_NEG_ONE     = 32'shFFFF_8000;
    localparam int                 SETTLE_CYCLES = 40;
    localparam int                 HOLD_CYCLES   = 300;
    localparam int                 ROW_COUNT     = 22;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [5:0]         index;
        logic               kind;
        logic signed [31:0] value;
        logic signed [31:0] level;
    } command_t;

    typedef struct packed {
        logic [5:0]         idx;
        logic signed [31:0] voltage;
        logic               spiked;
        logic               last;
    } neuron_report_t;

    // typed rows run with two active neurons and list both reports
    typedef struct packed {
        command_t           cmd;
        logic               typed;
        logic signed [31:0] v0;
        logic               s0;
        logic signed [31:0] v1;
        logic               s1;
    } directed_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         opcode;
    logic [5:0]         neuron_sel;
    logic               synapse_kind;
    logic signed [31:0] value;
    logic signed [31:0] fire_level;
    logic               out_valid;
    logic               out_ready;
    logic [5:0]         out_index;
    logic signed [31:0] recorded_voltage;
    logic               spiked;
    logic               last;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [6:0]         cfg_wdata;

    logic signed [31:0] membrane  [NEURONS];
    logic signed [31:0] threshold [NEURONS];
    logic signed [31:0] excite    [NEURONS];
    logic signed [31:0] inhibit   [NEURONS];
    logic [6:0]         active_count;

    neuron_report_t reports_due [$];
    int             mismatches;
    int             send_idle_pct;
    int             recv_idle_pct;
    int             hold_left;
    bit             stall_request;

    directed_row_t directed_rows [ROW_COUNT] = '{
        '{'{OP_LOAD, 6'd0, KIND_EXCITE, S32_MAX, S32_MAX}, 1'b0, '0, 1'b0, '0, 1'b0},
        '{'{OP_LOAD, 6'd1, KIND_INHIBIT, S32_MIN, S32_MIN}, 1'b0, '0, 1'b0, '0, 1'b0},
        '{'{OP_TICK, 6'd0, KIND_EXCITE, '0, '0}, 1'b1, S32_MAX, 1'b0, S32_MIN, 1'b0},
        '{'{OP_ADD, 6'd0, KIND_EXCITE, S32_MAX, '0}, 1'b0, '0, 1'b0, '0, 1'b0},
        '{'{OP_ADD, 6'd0, KIND_EXCITE, S32_MAX, '0}, 1'b0, '0, 1'b0, '0, 1'b0},
        '{'{OP_ADD, 6'd1, KIND_INHIBIT, S32_MAX, '0}, 1'b0, '0, 1'b0, '0, 1'b0},
        '{'{OP_ADD, 6'd1, KIND_INHIBIT, S32_MAX, '0}, 1'b0, '0, 1'b0, '0, 1'b0},
        '{'{OP_TICK, 6'd63, KIND_INHIBIT, S32_MAX, S32_MIN}, 1'b1, S32_MAX, 1'b0, S32_MIN, 1'b0},
        '{'{OP_ADD, 6'd0, KIND_INHIBIT, S32_MIN, '0}, 1'b0, '0, 1'b0, '0, 1'b0},
        '{'{OP_ADD, 6'd0, KIND_EXCITE, S32_MAX, '0}, 1'b0, '0, 1'b0, '0, 1'b0},
        '{'{OP_ADD, 6'd1, KIND_EXCITE, S32_MIN, '0}, 1'b0, '0, 1'b0, '0, 1'b0},
        '{'{OP_ADD, 6'd1, KIND_INHIBIT, S32_MAX, '0}, 1'b0, '0, 1'b0, '0, 1'b0},
        '{'{OP_TICK, 6'd0, KIND_EXCITE, '0, '0}, 1'b1, S32_MAX, 1'b0, S32_MIN, 1'b0},
        '{'{OP_LOAD, 6'd0, KIND_EXCITE, '0, '0}, 1'b0, '0, 1'b0, '0, 1'b0},
        '{'{OP_LOAD, 6'd1, KIND_EXCITE, V_ONE, V_NEG_ONE}, 1'b0, '0, 1'b0, '0, 1'b0},
        '{'{OP_ADD, 6'd0, KIND_EXCITE, 32'sd1, '0}, 1'b0, '0, 1'b0, '0, 1'b0},
        '{'{OP_ADD, 6'd1, KIND_INHIBIT, V_TWO, '0}, 1'b0, '0, 1'b0, '0, 1'b0},
        '{'{OP_UNUSED, 6'd63, KIND_INHIBIT, -32'sd1, -32'sd1}, 1'b0, '0, 1'b0, '0, 1'b0},
        '{'{OP_TICK, 6'd0, KIND_EXCITE, '0, '0}, 1'b1, '0, 1'b1, V_ONE, 1'b0},
        '{'{OP_TICK, 6'd0, KIND_EXCITE, '0, '0}, 1'b1, '0, 1'b0, V_NEG_ONE, 1'b0},
        '{'{OP_ADD, 6'd1, KIND_EXCITE, V_ONE, '0}, 1'b0, '0, 1'b0, '0, 1'b0},
        '{'{OP_TICK, 6'd0, KIND_EXCITE, '0, '0}, 1'b0, '0, 1'b0, '0, 1'b0}
    };

    integrate_fire_neuron_array u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .opcode           (opcode),
        .neuron_sel       (neuron_sel),
        .synapse_kind     (synapse_kind),
        .value            (value),
        .fire_level       (fire_level),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_index        (out_index),
        .recorded_voltage (recorded_voltage),
        .spiked           (spiked),
        .last             (last),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_wdata        (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic signed [31:0] sat32(input longint s);
        if (s > longint'(S32_MAX))
            return S32_MAX;
        if (s < longint'(S32_MIN))
            return S32_MIN;
        return 32'(s);
    endfunction

    function automatic int active_span();
        return (active_count > NEURONS) ? NEURONS : int'(active_count);
    endfunction

    // Integrate one command into the array; queue tick reports when publish is set.
    task automatic advance_array(input command_t c, input bit publish);
        longint v_prior;
        longint diff;
        longint after;
        bit     fired;
        int     count;
        int     n;
        case (c.opcode)
            OP_LOAD:
            begin
                membrane[c.index]  = c.value;
                threshold[c.index] = c.level;
                excite[c.index]    = '0;
                inhibit[c.index]   = '0;
            end
            OP_ADD:
            begin
                if (c.kind == KIND_INHIBIT)
                    inhibit[c.index] = sat32(longint'(inhibit[c.index]) + longint'(c.value));
                else
                    excite[c.index] = sat32(longint'(excite[c.index]) + longint'(c.value));
            end
            OP_TICK:
            begin
                count = active_span();
                for (n = 0; n < count; n++)
                begin
                    v_prior = membrane[n];
                    diff    = sat32(longint'(excite[n]) - longint'(inhibit[n]));
                    after   = sat32(v_prior + diff);
                    fired   = after > longint'(threshold[n]);
                    excite[n]   = '0;
                    inhibit[n]  = '0;
                    membrane[n] = fired ? '0 : 32'(after);
                    if (publish)
                        reports_due.push_back('{6'(n), 32'(v_prior), fired, n == count - 1});
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic offer_command(input command_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= c.opcode;
        neuron_sel   <= c.index;
        synapse_kind <= c.kind;
        value        <= c.value;
        fire_level   <= c.level;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic issue_command(input command_t c);
        advance_array(c, 1'b1);
        offer_command(c);
    endtask

    // Drain all reports and let queued loads and adds retire before touching the register.
    task automatic write_active(input logic [6:0] count);
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_wdata <= count;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid    <= 1'b0;
        active_count = count;
    endtask

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(9))
            0:       return S32_MAX;
            1:       return S32_MIN;
            2, 3:    return $urandom;
            default: return 32'($urandom_range(32'h60000)) - 32'sh20000;
        endcase
    endfunction

    function automatic logic [5:0] pick_neuron();
        int span;
        span = active_span();
        if (span == 0 || $urandom_range(3) == 0)
            return 6'($urandom_range(63));
        return 6'($urandom_range(span - 1));
    endfunction

    function automatic command_t random_command();
        command_t    c;
        int unsigned roll;
        roll    = $urandom_range(99);
        c.index = 6'($urandom);
        c.kind  = 1'($urandom);
        c.value = $urandom;
        c.level = $urandom;
        if (roll < 12)
        begin
            c.opcode = OP_LOAD;
            c.index  = pick_neuron();
            c.value  = rand_word();
            c.level  = rand_word();
        end
        else if (roll < 72)
        begin
            c.opcode = OP_ADD;
            c.index  = pick_neuron();
            c.value  = rand_word();
        end
        else if (roll < 94)
            c.opcode = OP_TICK;
        else
            c.opcode = OP_UNUSED;
        return c;
    endfunction

    task automatic run_phase(input logic [6:0] count, input int items, input int send_pct,
                             input int recv_pct, input bit squeeze);
        command_t c;
        write_active(count);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        if (squeeze)
        begin
            // hold the output so the tick backs up and the input stalls behind it
            stall_request = 1'b1;
            c = '{OP_TICK, 6'd0, KIND_EXCITE, '0, '0};
            issue_command(c);
        end
        repeat (items)
        begin
            c = random_command();
            issue_command(c);
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin : drain
        neuron_report_t got;
        neuron_report_t want;
        out_ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got = '{out_index, recorded_voltage, spiked, last};
                if (reports_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: index %0d voltage %0d spiked %0b last %0b",
                                 got.idx, got.voltage, got.spiked, got.last);
                end
                else
                begin
                    want = reports_due.pop_front();
                    if (got.idx !== want.idx || got.voltage !== want.voltage ||
                        got.spiked !== want.spiked || got.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"bad word: index %0d/%0d voltage %0d/%0d ",
                                      "spiked %0b/%0b last %0b/%0b (exp/act)"},
                                     want.idx, got.idx, want.voltage, got.voltage,
                                     want.spiked, got.spiked, want.last, got.last);
                    end
                end
            end
            if (stall_request)
            begin
                stall_request = 1'b0;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin : stimulus
        command_t c;
        int       i;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        opcode        = OP_LOAD;
        neuron_sel    = '0;
        synapse_kind  = KIND_EXCITE;
        value         = '0;
        fire_level    = '0;
        cfg_valid     = 1'b0;
        cfg_wdata     = '0;
        mismatches    = 0;
        stall_request = 1'b0;
        send_idle_pct = 22;
        recv_idle_pct = 82;
        active_count  = ACTIVE_RESET;
        for (i = 0; i < NEURONS; i++)
        begin
            membrane[i]  = '0;
            threshold[i] = '0;
            excite[i]    = '0;
            inhibit[i]   = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // load every neuron so any tick below reads written state; tick at the reset count
        for (i = 0; i < NEURONS; i++)
        begin
            c = '{OP_LOAD, 6'(i), 1'($urandom), rand_word(), rand_word()};
            issue_command(c);
        end
        c = '{OP_TICK, 6'($urandom), 1'($urandom), 32'($urandom), 32'($urandom)};
        issue_command(c);
        in_valid <= 1'b0;

        write_active(7'd2);
        for (i = 0; i < ROW_COUNT; i++)
        begin
            c = directed_rows[i].cmd;
            if (directed_rows[i].typed)
            begin
                advance_array(c, 1'b0);
                reports_due.push_back('{6'd0, directed_rows[i].v0, directed_rows[i].s0, 1'b0});
                reports_due.push_back('{6'd1, directed_rows[i].v1, directed_rows[i].s1, 1'b1});
            end
            else
                advance_array(c, 1'b1);
            offer_command(c);
        end
        in_valid <= 1'b0;

        run_phase(7'd1, 8, 22, 82, 1'b0);
        run_phase(7'd127, 5, 22, 82, 1'b0);
        run_phase(7'd0, 8, 82, 22, 1'b0);
        run_phase(7'($urandom_range(1, NEURONS)), 8, 82, 22, 1'b0);
        run_phase(7'd64, 8, 0, 0, 1'b1);
        run_phase(7'($urandom_range(2, 8)), 6, 0, 0, 1'b0);

        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && reports_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/ifna_pkg.sv
rtl/ifna_front.sv
rtl/ifna_queue.sv
rtl/ifna_back.sv
rtl/integrate_fire_neuron_array.sv
tb/integrate_fire_neuron_array_test.sv
